>>> hw/rtl/frqg_pkg.sv
// Shared constants, types and the average update function for the frame rate governor.
`timescale 1ns / 1ps
`default_nettype none

package frqg_pkg;

  localparam int unsigned AvgW    = 26;
  localparam int unsigned SampleW = 18;
  localparam int unsigned WeightW = 13;
  localparam int unsigned DwellW  = 8;
  localparam int unsigned CountW  = 2;
  localparam int unsigned ElapsedW = 32;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 26;

  // a sample counts only when it is in (0, SampleCeiling]
  localparam logic [SampleW-1:0] SampleCeiling = 18'd250000;

  localparam logic [WeightW-1:0] DeltaWeight = 13'd3277;
  localparam logic [WeightW-1:0] GpuWeight   = 13'd6554;

  localparam logic [AvgW-1:0]   FastPeriodReset  = 26'd2327272;
  localparam logic [AvgW-1:0]   MidPeriodReset   = 26'd3200000;
  localparam logic [AvgW-1:0]   GpuFastReset     = 26'd1920000;
  localparam logic [AvgW-1:0]   GpuMidReset      = 26'd2816000;
  localparam logic [AvgW-1:0]   GpuOverloadReset = 26'd8448000;
  localparam logic [DwellW-1:0] DownDwellReset   = 8'd30;
  localparam logic [DwellW-1:0] UpDwellReset     = 8'd180;
  localparam logic [CountW-1:0] InitSamplesReset = 2'd1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FAST_PERIOD  = 3'd0,
    REG_MID_PERIOD   = 3'd1,
    REG_GPU_FAST     = 3'd2,
    REG_GPU_MID      = 3'd3,
    REG_GPU_OVERLOAD = 3'd4,
    REG_DOWN_DWELL   = 3'd5,
    REG_UP_DWELL     = 3'd6,
    REG_INIT_SAMPLES = 3'd7
  } cfg_reg_t;

  // limits used by the decision stage
  typedef struct packed {
    logic [AvgW-1:0]   fast_period;
    logic [AvgW-1:0]   mid_period;
    logic [AvgW-1:0]   gpu_fast;
    logic [AvgW-1:0]   gpu_mid;
    logic [AvgW-1:0]   gpu_overload;
    logic [DwellW-1:0] down_dwell;
    logic [DwellW-1:0] up_dwell;
  } cfg_t;

  // interval stage to average stage
  typedef struct packed {
    logic [ElapsedW-1:0] elapsed;
    logic                delta_ok;
    logic [SampleW-1:0]  gpu_sample;
    logic                gpu_ok;
  } s1_t;

  // avg' = avg + round(((s << 8) - avg) * w / 65536), which equals
  // (avg*(65536-w) + (s<<8)*w + 32768) >> 16. Empty average is seeded.
  function automatic logic [AvgW-1:0] ema_step(input logic [AvgW-1:0]    avg,
                                               input logic [SampleW-1:0] sample,
                                               input logic [WeightW-1:0] weight);
    logic [AvgW-1:0]        scaled;
    logic signed [AvgW:0]   diff;
    logic signed [AvgW+WeightW+1:0] prod;
    logic signed [AvgW+WeightW+1:0] step;
    logic [AvgW:0]          sum;
    scaled = {sample, 8'd0};
    diff   = $signed({1'b0, scaled}) - $signed({1'b0, avg});
    prod   = diff * $signed({1'b0, weight});
    step   = (prod + (AvgW+WeightW+2)'(32768)) >>> 16;
    sum    = {1'b0, avg} + step[AvgW:0];
    if (avg == '0) begin
      return scaled;
    end
    return sum[AvgW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/frqg_interval.sv
// Interval stage: elapsed time since the previous frame and sample qualification.
`timescale 1ns / 1ps
`default_nettype none

module frqg_interval (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              advance,
  input  wire logic                              in_valid,
  input  wire logic [frqg_pkg::TimeW-1:0]        now_us,
  input  wire logic [frqg_pkg::ElapsedW-1:0]     gpu_frame_us,
  output logic                                   s1_valid,
  output frqg_pkg::s1_t                          s1
);

  logic [frqg_pkg::TimeW-1:0]    last_time_r;
  logic                          time_seen_r;
  logic                          s1_valid_r;
  frqg_pkg::s1_t                 s1_r;
  frqg_pkg::s1_t                 s1_nxt;
  logic [frqg_pkg::TimeW-1:0]    diff;
  logic [frqg_pkg::ElapsedW-1:0] elapsed;

  always_comb begin
    diff = now_us - last_time_r;
    elapsed = '0;
    if (time_seen_r && (now_us >= last_time_r)) begin
      elapsed = (diff[frqg_pkg::TimeW-1:frqg_pkg::ElapsedW] != '0) ? '1
                                                               : diff[frqg_pkg::ElapsedW-1:0];
    end
    s1_nxt.elapsed    = elapsed;
    s1_nxt.delta_ok   = (elapsed != '0) &&
                        (elapsed <= frqg_pkg::ElapsedW'(frqg_pkg::SampleCeiling));
    s1_nxt.gpu_sample = gpu_frame_us[frqg_pkg::SampleW-1:0];
    s1_nxt.gpu_ok     = (gpu_frame_us != '0) &&
                        (gpu_frame_us <= frqg_pkg::ElapsedW'(frqg_pkg::SampleCeiling));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      time_seen_r <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
      if (in_valid) begin
        last_time_r <= now_us;
        time_seen_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

`default_nettype wire

>>> hw/rtl/frqg_avg.sv
// Average stage: frame interval and GPU time moving averages.
`timescale 1ns / 1ps
`default_nettype none

module frqg_avg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire logic                          s1_valid,
  input  wire frqg_pkg::s1_t                 s1,
  output logic                               s2_valid,
  output logic [frqg_pkg::ElapsedW-1:0]      s2_elapsed,
  output logic [frqg_pkg::AvgW-1:0]          delta_avg,
  output logic [frqg_pkg::AvgW-1:0]          gpu_avg
);

  logic                          s2_valid_r;
  logic [frqg_pkg::ElapsedW-1:0] s2_elapsed_r;
  logic [frqg_pkg::AvgW-1:0]     delta_avg_r;
  logic [frqg_pkg::AvgW-1:0]     gpu_avg_r;
  logic [frqg_pkg::AvgW-1:0]     delta_avg_nxt;
  logic [frqg_pkg::AvgW-1:0]     gpu_avg_nxt;

  always_comb begin
    delta_avg_nxt = frqg_pkg::ema_step(delta_avg_r, s1.elapsed[frqg_pkg::SampleW-1:0],
                                       frqg_pkg::DeltaWeight);
    gpu_avg_nxt   = frqg_pkg::ema_step(gpu_avg_r, s1.gpu_sample, frqg_pkg::GpuWeight);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      delta_avg_r <= '0;
      gpu_avg_r   <= '0;
    end else if (advance) begin
      s2_valid_r <= s1_valid;
      if (s1_valid && s1.delta_ok) begin
        delta_avg_r <= delta_avg_nxt;
      end
      if (s1_valid && s1.gpu_ok) begin
        gpu_avg_r <= gpu_avg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      s2_elapsed_r <= s1.elapsed;
    end
  end

  assign s2_valid   = s2_valid_r;
  assign s2_elapsed = s2_elapsed_r;
  assign delta_avg  = delta_avg_r;
  assign gpu_avg    = gpu_avg_r;

endmodule

`default_nettype wire

>>> hw/rtl/frqg_decide.sv
// Decision stage: desired sample count, dwell tracking and the result register.
`timescale 1ns / 1ps
`default_nettype none

module frqg_decide (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire frqg_pkg::cfg_t                cfg,
  input  wire logic                          init_load,
  input  wire logic [frqg_pkg::CountW-1:0]   init_value,
  input  wire logic                          s2_valid,
  input  wire logic [frqg_pkg::ElapsedW-1:0] s2_elapsed,
  input  wire logic [frqg_pkg::AvgW-1:0]     delta_avg,
  input  wire logic [frqg_pkg::AvgW-1:0]     gpu_avg,
  output logic                               out_valid,
  output logic [frqg_pkg::ElapsedW-1:0]      out_elapsed,
  output logic [frqg_pkg::CountW-1:0]        out_samples,
  output logic                               out_changed
);

  logic [frqg_pkg::CountW-1:0]   cand_r, cand_nxt;
  logic [frqg_pkg::DwellW-1:0]   frames_r, frames_nxt;
  logic [frqg_pkg::CountW-1:0]   active_r, active_nxt;
  logic                          changed_nxt;
  logic [frqg_pkg::CountW-1:0]   desired;
  logic [frqg_pkg::DwellW-1:0]   dwell;
  logic                          out_valid_r;
  logic [frqg_pkg::ElapsedW-1:0] out_elapsed_r;
  logic                          out_changed_r;

  always_comb begin
    cand_nxt    = cand_r;
    frames_nxt  = frames_r;
    active_nxt  = active_r;
    changed_nxt = 1'b0;
    desired     = 2'd1;
    if ((delta_avg <= cfg.fast_period) && ((gpu_avg == '0) || (gpu_avg <= cfg.gpu_fast))) begin
      desired = 2'd3;
    end else if ((delta_avg <= cfg.mid_period) &&
                 ((gpu_avg == '0) || (gpu_avg <= cfg.gpu_mid))) begin
      desired = 2'd2;
    end else if (gpu_avg >= cfg.gpu_overload) begin
      desired = 2'd0;
    end
    dwell = (desired < active_r) ? cfg.down_dwell : cfg.up_dwell;
    if (delta_avg != '0) begin
      if (desired != cand_r) begin
        cand_nxt   = desired;
        frames_nxt = 8'd1;
      end else if (frames_r != '1) begin
        frames_nxt = frames_r + 8'd1;
      end
      if ((desired != active_r) && (frames_nxt >= dwell)) begin
        active_nxt  = desired;
        frames_nxt  = '0;
        changed_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r      <= frqg_pkg::InitSamplesReset;
      frames_r    <= '0;
      active_r    <= frqg_pkg::InitSamplesReset;
      out_valid_r <= 1'b0;
    end else if (init_load) begin
      cand_r   <= init_value;
      frames_r <= '0;
      active_r <= init_value;
    end else if (advance) begin
      out_valid_r <= s2_valid;
      if (s2_valid) begin
        cand_r   <= cand_nxt;
        frames_r <= frames_nxt;
        active_r <= active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid) begin
      out_elapsed_r <= s2_elapsed;
      out_changed_r <= changed_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_elapsed = out_elapsed_r;
  assign out_samples = active_r;
  assign out_changed = out_changed_r;

endmodule

`default_nettype wire

>>> hw/rtl/frame_rate_quality_governor_unit.sv
// Top level of the frame rate quality governor: config registers and the three-stage pipe.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------------
//  in_     | in  | in_tvalid / in_tready   | tdata: now_us[63:0], gpu_frame_us[95:64]
//  out_    | out | out_tvalid / out_tready | tdata: elapsed_us[31:0],
//          |     |                        |   interpolation_samples[33:32],
//          |     |                        |   samples_changed[34], zero [39:35]
//  cfg_    | in  | cfg_we                 | cfg_addr register index, cfg_wdata value
//
// One item per cycle sustained while the result side keeps taking items; an item that is
// taken passes through the interval register, then the average register, then the
// decision/result register, which drives out_tvalid and from which it leaves.
// Each stage carries its own state, so items follow back to back without forwarding.
// The whole pipe moves together: it advances whenever the result register is empty
// or being taken, and in_tready is that same advance condition.
// rst_n (synchronous) empties the pipe, clears timestamps and averages, reloads the
// register defaults and sets the sample count to the default initial value.
// Writing initial_samples reloads the count in effect and the candidate.
`timescale 1ns / 1ps
`default_nettype none

module frame_rate_quality_governor_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [95:0]                       in_tdata,   // now_us, gpu_frame_us
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [39:0]                            out_tdata,  // elapsed_us, interpolation_samples,
                                                             // samples_changed, pad
  input  wire logic                              cfg_we,
  input  wire logic [frqg_pkg::CfgIdxW-1:0]      cfg_addr,
  input  wire logic [frqg_pkg::CfgDataW-1:0]     cfg_wdata
);

  frqg_pkg::cfg_t                cfg_r;
  logic [frqg_pkg::CountW-1:0]   init_samples_r;
  logic                          init_load;
  logic                          advance;
  logic                          s1_valid;
  frqg_pkg::s1_t                 s1;
  logic                          s2_valid;
  logic [frqg_pkg::ElapsedW-1:0] s2_elapsed;
  logic [frqg_pkg::AvgW-1:0]     delta_avg;
  logic [frqg_pkg::AvgW-1:0]     gpu_avg;
  logic [frqg_pkg::ElapsedW-1:0] out_elapsed;
  logic [frqg_pkg::CountW-1:0]   out_samples;
  logic                          out_changed;

  // whole pipe steps when the result slot is free or draining
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;

  assign init_load = cfg_we && (frqg_pkg::cfg_reg_t'(cfg_addr) == frqg_pkg::REG_INIT_SAMPLES);

  // register file; the user must write it only while the pipe is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fast_period  <= frqg_pkg::FastPeriodReset;
      cfg_r.mid_period   <= frqg_pkg::MidPeriodReset;
      cfg_r.gpu_fast     <= frqg_pkg::GpuFastReset;
      cfg_r.gpu_mid      <= frqg_pkg::GpuMidReset;
      cfg_r.gpu_overload <= frqg_pkg::GpuOverloadReset;
      cfg_r.down_dwell   <= frqg_pkg::DownDwellReset;
      cfg_r.up_dwell     <= frqg_pkg::UpDwellReset;
      init_samples_r     <= frqg_pkg::InitSamplesReset;
    end else if (cfg_we) begin
      unique case (frqg_pkg::cfg_reg_t'(cfg_addr))
        frqg_pkg::REG_FAST_PERIOD:  cfg_r.fast_period  <= cfg_wdata;
        frqg_pkg::REG_MID_PERIOD:   cfg_r.mid_period   <= cfg_wdata;
        frqg_pkg::REG_GPU_FAST:     cfg_r.gpu_fast     <= cfg_wdata;
        frqg_pkg::REG_GPU_MID:      cfg_r.gpu_mid      <= cfg_wdata;
        frqg_pkg::REG_GPU_OVERLOAD: cfg_r.gpu_overload <= cfg_wdata;
        frqg_pkg::REG_DOWN_DWELL:   cfg_r.down_dwell   <= cfg_wdata[frqg_pkg::DwellW-1:0];
        frqg_pkg::REG_UP_DWELL:     cfg_r.up_dwell     <= cfg_wdata[frqg_pkg::DwellW-1:0];
        frqg_pkg::REG_INIT_SAMPLES: init_samples_r     <= cfg_wdata[frqg_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  frqg_interval u_interval (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .in_valid     (in_tvalid),
    .now_us       (in_tdata[63:0]),
    .gpu_frame_us (in_tdata[95:64]),
    .s1_valid     (s1_valid),
    .s1           (s1)
  );

  frqg_avg u_avg (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s2_valid   (s2_valid),
    .s2_elapsed (s2_elapsed),
    .delta_avg  (delta_avg),
    .gpu_avg    (gpu_avg)
  );

  // init_samples_r only feeds the decision stage through the load value below;
  // the stage reloads on the same edge the register is written
  frqg_decide u_decide (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .cfg         (cfg_r),
    .init_load   (init_load),
    .init_value  (init_load ? cfg_wdata[frqg_pkg::CountW-1:0] : init_samples_r),
    .s2_valid    (s2_valid),
    .s2_elapsed  (s2_elapsed),
    .delta_avg   (delta_avg),
    .gpu_avg     (gpu_avg),
    .out_valid   (out_tvalid),
    .out_elapsed (out_elapsed),
    .out_samples (out_samples),
    .out_changed (out_changed)
  );

  assign out_tdata = {5'd0, out_changed, out_samples, out_elapsed};

endmodule

`default_nettype wire

>>> hw/rtl/frqg_checker.sv
// Port-level checks for the frame rate quality governor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module frqg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  // a held result keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // input side is open exactly when the result slot can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("in_tready does not follow result slot");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // pad bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[39:35] == 5'd0))
    else $error("result pad bits set");

endmodule

bind frame_rate_quality_governor_unit frqg_checker u_frqg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

>>> tb/frqg_checker.sv
// Frame rate governor checker: predicts each result item from the input and config traffic.
`timescale 1ns / 1ps

module frqg_scoreboard (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  input  wire logic                              in_tready,
  input  wire logic [95:0]                       in_tdata,   // now_us, gpu_frame_us
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic [39:0]                       out_tdata,  // elapsed_us, interpolation_samples,
                                                             // samples_changed, pad
  input  wire logic                              cfg_we,
  input  wire logic [frqg_pkg::CfgIdxW-1:0]      cfg_addr,
  input  wire logic [frqg_pkg::CfgDataW-1:0]     cfg_wdata,
  output int unsigned                            mismatches,
  output int unsigned                            results_pending
);

  localparam int AvgBits = 26;
  localparam logic [31:0] CeilingUs  = 32'd250000;
  localparam logic [15:0] IntervalWt = 16'd3277;
  localparam logic [15:0] GpuWt      = 16'd6554;

  typedef struct packed {
    logic [31:0] elapsed_us;
    logic [1:0]  samples;
    logic        changed;
  } frame_result_t;

  frame_result_t expected_frames[$];

  // config copy
  logic [AvgBits-1:0] fast_limit, mid_limit, gpu_fast_limit, gpu_mid_limit, overload_limit;
  logic [7:0]         down_dwell, up_dwell;
  logic [1:0]         init_samples;

  // governor state copy
  logic [63:0]        last_stamp;
  logic               stamp_seen;
  logic [AvgBits-1:0] interval_avg, gpu_avg;
  logic [1:0]         cand_count, active_count;
  logic [7:0]         cand_frames;

  // EMA step, rounded to nearest; an empty average takes the sample scaled by 256
  function automatic logic [AvgBits-1:0] blend_average(input logic [AvgBits-1:0] avg,
                                                       input logic [31:0] sample_us,
                                                       input logic [15:0] weight);
    logic [63:0] scaled;
    logic [63:0] acc;
    scaled = {32'd0, sample_us} << 8;
    if (avg == '0) return scaled[AvgBits-1:0];
    acc = 64'(avg) * (64'd65536 - 64'(weight)) + scaled * 64'(weight) + 64'd32768;
    return acc[16 +: AvgBits];
  endfunction

  function automatic frame_result_t advance_governor(input logic [63:0] now_us,
                                                     input logic [31:0] gpu_us);
    frame_result_t r;
    logic [63:0]   span;
    logic [1:0]    desired;
    logic [7:0]    dwell;
    r = '0;
    if (stamp_seen && now_us >= last_stamp) begin
      span = now_us - last_stamp;
      r.elapsed_us = (span > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
    end
    last_stamp = now_us;
    stamp_seen = 1'b1;

    if (r.elapsed_us != 0 && r.elapsed_us <= CeilingUs)
      interval_avg = blend_average(interval_avg, r.elapsed_us, IntervalWt);
    if (gpu_us != 0 && gpu_us <= CeilingUs)
      gpu_avg = blend_average(gpu_avg, gpu_us, GpuWt);

    // no decision until the interval average exists
    if (interval_avg != '0) begin
      if (interval_avg <= fast_limit && (gpu_avg == '0 || gpu_avg <= gpu_fast_limit))
        desired = 2'd3;
      else if (interval_avg <= mid_limit && (gpu_avg == '0 || gpu_avg <= gpu_mid_limit))
        desired = 2'd2;
      else if (gpu_avg >= overload_limit)
        desired = 2'd0;
      else
        desired = 2'd1;

      if (desired != cand_count) begin
        cand_count  = desired;
        cand_frames = 8'd1;
      end else if (cand_frames != 8'hFF) begin
        cand_frames = cand_frames + 8'd1;
      end

      dwell = (desired < active_count) ? down_dwell : up_dwell;
      if (desired != active_count && cand_frames >= dwell) begin
        active_count = desired;
        cand_frames  = 8'd0;
        r.changed    = 1'b1;
      end
    end
    r.samples = active_count;
    return r;
  endfunction

  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (!rst_n) begin
      fast_limit     = frqg_pkg::FastPeriodReset;
      mid_limit      = frqg_pkg::MidPeriodReset;
      gpu_fast_limit = frqg_pkg::GpuFastReset;
      gpu_mid_limit  = frqg_pkg::GpuMidReset;
      overload_limit = frqg_pkg::GpuOverloadReset;
      down_dwell     = frqg_pkg::DownDwellReset;
      up_dwell       = frqg_pkg::UpDwellReset;
      init_samples   = frqg_pkg::InitSamplesReset;
      last_stamp     = '0;
      stamp_seen     = 1'b0;
      interval_avg   = '0;
      gpu_avg        = '0;
      cand_count     = frqg_pkg::InitSamplesReset;
      active_count   = frqg_pkg::InitSamplesReset;
      cand_frames    = '0;
      mismatches     = 0;
      expected_frames.delete();
    end else begin
      // results first: an item taken at this edge cannot leave at it
      if (out_tvalid && out_tready) begin
        got = {out_tdata[31:0], out_tdata[33:32], out_tdata[34]};
        if (expected_frames.size() == 0) begin
          $error("result item with nothing expected: %h", out_tdata);
          mismatches++;
        end else begin
          want = expected_frames.pop_front();
          if (got.elapsed_us !== want.elapsed_us) begin
            $error("elapsed_us: expected %0d, got %0d", want.elapsed_us, got.elapsed_us);
            mismatches++;
          end
          if (got.samples !== want.samples) begin
            $error("interpolation_samples: expected %0d, got %0d", want.samples, got.samples);
            mismatches++;
          end
          if (got.changed !== want.changed) begin
            $error("samples_changed: expected %0d, got %0d", want.changed, got.changed);
            mismatches++;
          end
        end
      end

      if (cfg_we) begin
        case (frqg_pkg::cfg_reg_t'(cfg_addr))
          frqg_pkg::REG_FAST_PERIOD:  fast_limit     = cfg_wdata;
          frqg_pkg::REG_MID_PERIOD:   mid_limit      = cfg_wdata;
          frqg_pkg::REG_GPU_FAST:     gpu_fast_limit = cfg_wdata;
          frqg_pkg::REG_GPU_MID:      gpu_mid_limit  = cfg_wdata;
          frqg_pkg::REG_GPU_OVERLOAD: overload_limit = cfg_wdata;
          frqg_pkg::REG_DOWN_DWELL:   down_dwell     = cfg_wdata[7:0];
          frqg_pkg::REG_UP_DWELL:     up_dwell       = cfg_wdata[7:0];
          frqg_pkg::REG_INIT_SAMPLES: begin
            init_samples = cfg_wdata[1:0];
            active_count = cfg_wdata[1:0];
            cand_count   = cfg_wdata[1:0];
            cand_frames  = '0;
          end
          default: ;
        endcase
      end

      if (in_tvalid && in_tready)
        expected_frames.push_back(advance_governor(in_tdata[63:0], in_tdata[95:64]));
    end
    results_pending = expected_frames.size();
  end

endmodule

>>> tb/tb_top.sv
// Testbench top for the frame rate governor: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;

  // cycles with no handshake at all before the run is declared hung; the longest
  // honest quiet spell is the forced receiver hold of HoldCycles
  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 60;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [95:0]                   in_tdata;   // now_us[63:0], gpu_frame_us[95:64]
  logic                          out_tvalid;
  logic                          out_tready;
  logic [39:0]                   out_tdata;  // elapsed_us[31:0], interpolation_samples[33:32],
                                             // samples_changed[34], zero pad
  logic                          cfg_we;
  logic [frqg_pkg::CfgIdxW-1:0]  cfg_addr;
  logic [frqg_pkg::CfgDataW-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned results_pending;
  int unsigned quiet_cycles;

  bit          idle_on;       // random gaps on both sides
  bit          hold_results;  // asks the sink for one long stall

  // traffic shape: timestamps advance by a regime's frame interval
  logic [63:0] frame_clock;
  int unsigned delta_lo, delta_hi, gpu_lo, gpu_hi;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  frame_rate_quality_governor_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  frqg_scoreboard frame_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  // watchdog: counts cycles in which no channel moves anything
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result sink: random stall bursts, or one long hold on request
  initial begin : result_sink
    int unsigned stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_results) begin
        out_tready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_results = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 12);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // one item on the input channel; returns just after the accepting edge
  task automatic push_frame(input logic [63:0] now_us, input logic [31:0] gpu_us);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {gpu_us, now_us};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input frqg_pkg::cfg_reg_t idx,
                           input logic [frqg_pkg::CfgDataW-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // registers change only with the pipe empty
  task automatic load_settings(input logic [25:0] fast, input logic [25:0] mid,
                               input logic [25:0] gfast, input logic [25:0] gmid,
                               input logic [25:0] gover, input logic [7:0] down,
                               input logic [7:0] up, input logic [1:0] init);
    wait_drained();
    write_reg(frqg_pkg::REG_FAST_PERIOD,  fast);
    write_reg(frqg_pkg::REG_MID_PERIOD,   mid);
    write_reg(frqg_pkg::REG_GPU_FAST,     gfast);
    write_reg(frqg_pkg::REG_GPU_MID,      gmid);
    write_reg(frqg_pkg::REG_GPU_OVERLOAD, gover);
    write_reg(frqg_pkg::REG_DOWN_DWELL,   26'(down));
    write_reg(frqg_pkg::REG_UP_DWELL,     26'(up));
    write_reg(frqg_pkg::REG_INIT_SAMPLES, 26'(init));
  endtask

  // limits near the defaults, or anywhere in the 26-bit range when wide
  task automatic load_random_settings(input bit wide);
    logic [25:0] fast, mid, gfast, gmid, gover;
    fast  = wide ? 26'($urandom) : 26'($urandom_range(1_800_000, 3_000_000));
    mid   = wide ? 26'($urandom) : fast + 26'($urandom_range(0, 1_500_000));
    gfast = wide ? 26'($urandom) : 26'($urandom_range(1_000_000, 2_600_000));
    gmid  = wide ? 26'($urandom) : gfast + 26'($urandom_range(0, 1_500_000));
    gover = wide ? 26'($urandom) : 26'($urandom_range(5_000_000, 12_000_000));
    load_settings(fast, mid, gfast, gmid, gover, 8'($urandom_range(1, 12)),
                  8'($urandom_range(1, 12)), 2'($urandom_range(0, 3)));
  endtask

  // frame interval and GPU time bands: fast, mid and slow pacing, with the GPU
  // light, moderate, heavy or overloaded against the default limits
  task automatic pick_regime();
    case ($urandom_range(0, 2))
      0:       begin delta_lo = 5000;  delta_hi = 8800;  end
      1:       begin delta_lo = 9500;  delta_hi = 12200; end
      default: begin delta_lo = 13500; delta_hi = 30000; end
    endcase
    case ($urandom_range(0, 3))
      0:       begin gpu_lo = 1000;  gpu_hi = 7000;  end
      1:       begin gpu_lo = 8000;  gpu_hi = 10500; end
      2:       begin gpu_lo = 12000; gpu_hi = 30000; end
      default: begin gpu_lo = 34000; gpu_hi = 90000; end
    endcase
  endtask

  // mostly steady frames within a regime that holds long enough for the averages
  // to settle; the rest is clock noise and out-of-range GPU readings
  task automatic run_frames(input int unsigned count);
    logic [63:0] now_us;
    logic [31:0] gpu_us;
    int unsigned left;
    left = 0;
    repeat (count) begin
      if (left == 0) begin
        pick_regime();
        left = $urandom_range(30, 70);
      end
      left--;
      if ($urandom_range(0, 99) < 85) begin
        frame_clock = frame_clock + 64'($urandom_range(delta_lo, delta_hi));
        gpu_us = $urandom_range(gpu_lo, gpu_hi);
      end else begin
        case ($urandom_range(0, 4))
          0: frame_clock = frame_clock - 64'($urandom_range(1, 50000));          // backwards
          1: ;                                                                   // same stamp
          2: frame_clock = frame_clock + 64'($urandom_range(250001, 5_000_000)); // stall
          3: frame_clock = frame_clock + {32'($urandom), 32'($urandom)};          // wild jump
          default: frame_clock = {32'($urandom), 32'($urandom)};                 // arbitrary
        endcase
        case ($urandom_range(0, 2))
          0:       gpu_us = 32'd0;
          1:       gpu_us = $urandom;
          default: gpu_us = $urandom_range(250001, 2_000_000);
        endcase
      end
      now_us = frame_clock;
      push_frame(now_us, gpu_us);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_addr     = frqg_pkg::REG_FAST_PERIOD;
    cfg_wdata    = '0;
    idle_on      = 1'b0;
    hold_results = 1'b0;
    frame_clock  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed frames under the reset defaults
    push_frame(64'd0, 32'd0);                      // first frame, stamp zero
    push_frame(64'd8000, 32'd0);                   // seeds interval avg, GPU avg still empty
    push_frame(64'd16000, 32'd5000);               // seeds GPU avg
    push_frame(64'd16000, 32'd250000);             // zero elapsed, GPU at ceiling
    push_frame(64'd266000, 32'd250001);            // interval at ceiling, GPU above it
    push_frame(64'd516001, 32'd1);                 // interval just above ceiling
    push_frame(64'd500000, 32'hFFFF_FFFF);         // time goes backwards
    push_frame(64'd500000 + 64'h1_0000_0005, 32'd7000);        // elapsed saturates
    push_frame(64'd500000 + 64'h1_0000_0005 + 64'hFFFF_FFFF, 32'd7000); // elapsed max exact
    push_frame(64'hFFFF_FFFF_FFFF_FFFF, 32'd6000); // top of the stamp range
    push_frame(64'd0, 32'd6000);                   // backwards from the top
    push_frame(64'd1, 32'd6000);                   // smallest interval
    frame_clock = 64'd1;
    repeat (12) begin
      frame_clock = frame_clock + 64'd8000;
      push_frame(frame_clock, 32'd5000);
    end

    idle_on = 1'b1;
    run_frames(40);

    // short dwells; then the receiver holds off while items keep coming,
    // and afterwards the sender waits for every result
    load_settings(26'd2327272, 26'd3200000, 26'd1920000, 26'd2816000, 26'd8448000,
                  8'd3, 8'd5, 2'd2);
    run_frames(40);
    idle_on      = 1'b0;
    hold_results = 1'b1;
    run_frames(20);
    wait_drained();
    idle_on = 1'b1;
    run_frames(30);

    // every limit at its top, zero dwell switches at once
    load_settings('1, '1, '1, '1, '1, 8'd0, 8'd0, 2'd0);
    run_frames(50);

    // every limit zero: overload everywhere, slow to climb
    load_settings('0, '0, '0, '0, '0, 8'd1, 8'd255, 2'd3);
    run_frames(40);

    load_random_settings(1'b1);
    run_frames(60);
    load_random_settings(1'b0);
    run_frames(70);
    load_random_settings(1'b0);
    run_frames(70);

    // defaults again with the dwell extremes the other way round
    load_settings(26'd2327272, 26'd3200000, 26'd1920000, 26'd2816000, 26'd8448000,
                  8'd255, 8'd1, 2'd1);
    run_frames(50);

    // closing stretch at full rate on both sides
    load_random_settings(1'b0);
    idle_on = 1'b0;
    run_frames(80);

    wait_drained();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> frame_rate_quality_governor_unit.f
hw/rtl/frqg_pkg.sv
hw/rtl/frqg_interval.sv
hw/rtl/frqg_avg.sv
hw/rtl/frqg_decide.sv
hw/rtl/frame_rate_quality_governor_unit.sv
hw/rtl/frqg_checker.sv
tb/frqg_checker.sv
tb/tb_top.sv
